// File: hw/rtl/csub_pkg.sv
`timescale 1ns / 1ps

package csub_pkg;

   localparam int CSUB_MAX_LINE   = 64;
   localparam int SAMPLE_W        = 8;
   localparam int LINE_W          = 7;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 7;

   localparam logic [LINE_W-1:0] LINE_WIDTH_RESET = 7'd16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HORIZ_ENABLE = 2'd0,
      CSR_VERT_ENABLE  = 2'd1,
      CSR_LINE_WIDTH   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                is_luma;
   } csub_req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] out_sample;
      logic                out_is_luma;
   } csub_rsp_type;

   // what the front end hands to the middle stage for one item
   typedef struct packed {
      logic                emit;
      logic                avg;
      logic                is_luma;
      logic [SAMPLE_W-1:0] value;
   } csub_stage_type;

endpackage

// File: hw/rtl/chroma_subsample_2x_top.sv
`timescale 1ns / 1ps

// 2x chroma subsampler for an 8-bit MCU sample stream. One sample is taken per
// clock with no bubbles while the output is not stalled; luma passes straight
// through, chroma is averaged in horizontal pairs and/or vertical line pairs as
// the csr registers select (index 0 horizontal enable, 1 vertical enable, 2
// line width, reset 0/0/16). An item enters the front stage, moves into a
// registered middle stage where the line buffer read completes, and lands in
// the output register; the line buffer port (one write or one read per item)
// sets the one-item-per-clock rate. Items that start a pair or fill the even
// line give no result. Program the registers only while the block is empty,
// and never make an odd line read a column that its even line did not write.
module chroma_subsample_2x_top
   import csub_pkg::*;
#(
   parameter int MAX_LINE = CSUB_MAX_LINE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  csub_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output csub_rsp_type           rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int ADDR_W = $clog2(MAX_LINE);

   csub_stage_type      stage_info;
   logic                mem_we;
   logic                mem_re;
   logic [ADDR_W-1:0]   mem_addr;
   logic [SAMPLE_W-1:0] mem_wdata;
   logic [SAMPLE_W-1:0] rd_data;
   logic                accept;

   assign accept = req_valid && req_ready;

   csub_ctrl #(
      .MAX_LINE (MAX_LINE),
      .ADDR_W   (ADDR_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req_data         (req_data),
      .stage_info       (stage_info),
      .mem_we           (mem_we),
      .mem_re           (mem_re),
      .mem_addr         (mem_addr),
      .mem_wdata        (mem_wdata)
   );

   csub_line_buf #(
      .MAX_LINE (MAX_LINE),
      .ADDR_W   (ADDR_W)
   ) u_line_buf (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .rd_data   (rd_data)
   );

   csub_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .stage_info (stage_info),
      .rd_data    (rd_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// File: hw/rtl/csub_ctrl.sv
`timescale 1ns / 1ps

module csub_ctrl
   import csub_pkg::*;
#(
   parameter int MAX_LINE = CSUB_MAX_LINE,
   parameter int ADDR_W   = $clog2(MAX_LINE)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  accept,
   input  csub_req_type          req_data,
   output csub_stage_type        stage_info,
   output logic                  mem_we,
   output logic                  mem_re,
   output logic [ADDR_W-1:0]     mem_addr,
   output logic [SAMPLE_W-1:0]   mem_wdata
);

   localparam int CMP_W = (ADDR_W + 1 > LINE_W) ? ADDR_W + 1 : LINE_W;

   logic                horiz_enable_ff;
   logic                vert_enable_ff;
   logic [LINE_W-1:0]   line_width_ff;

   logic [SAMPLE_W-1:0] held_sample_ff, held_sample_in;
   logic                pair_half_ff, pair_half_in;
   logic [ADDR_W-1:0]   column_count_ff, column_count_in;
   logic                odd_line_ff, odd_line_in;

   logic [LINE_W-1:0]   halved;
   logic [CMP_W-1:0]    width_raw;
   logic [CMP_W-1:0]    eff_width;
   logic [CMP_W-1:0]    col_ext;
   logic [CMP_W-1:0]    col_next;
   logic [SAMPLE_W:0]   pair_sum;
   logic [SAMPLE_W-1:0] horiz_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         horiz_enable_ff <= 1'b0;
         vert_enable_ff  <= 1'b0;
         line_width_ff   <= LINE_WIDTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HORIZ_ENABLE: horiz_enable_ff <= csr_write_data[0];
            CSR_VERT_ENABLE:  vert_enable_ff  <= csr_write_data[0];
            CSR_LINE_WIDTH:   line_width_ff   <= csr_write_data[LINE_W-1:0];
            default: ;
         endcase
      end
   end

   // reduced line width, clamped to 1..MAX_LINE
   always_comb begin
      halved    = horiz_enable_ff ? {1'b0, line_width_ff[LINE_W-1:1]} : line_width_ff;
      width_raw = CMP_W'(halved);
      if (width_raw == '0) begin
         eff_width = CMP_W'(1);
      end else if (width_raw > CMP_W'(MAX_LINE)) begin
         eff_width = CMP_W'(MAX_LINE);
      end else begin
         eff_width = width_raw;
      end
   end

   assign pair_sum    = {1'b0, held_sample_ff} + {1'b0, req_data.sample};
   assign horiz_value = horiz_enable_ff ? pair_sum[SAMPLE_W:1] : req_data.sample;

   // column restarts if a width change left it beyond the line
   assign col_ext  = (CMP_W'(column_count_ff) >= eff_width) ? '0 : CMP_W'(column_count_ff);
   assign col_next = col_ext + CMP_W'(1);

   always_comb begin
      held_sample_in     = held_sample_ff;
      pair_half_in       = pair_half_ff;
      column_count_in    = column_count_ff;
      odd_line_in        = odd_line_ff;
      stage_info.emit    = 1'b1;
      stage_info.avg     = 1'b0;
      stage_info.is_luma = req_data.is_luma;
      stage_info.value   = req_data.sample;
      mem_we             = 1'b0;
      mem_re             = 1'b0;
      mem_addr           = col_ext[ADDR_W-1:0];
      mem_wdata          = horiz_value;
      if (!req_data.is_luma) begin
         if (horiz_enable_ff && !pair_half_ff) begin
            held_sample_in  = req_data.sample;
            pair_half_in    = 1'b1;
            stage_info.emit = 1'b0;
         end else begin
            // a half pair survives while horizontal mode is off
            if (horiz_enable_ff) begin
               pair_half_in = 1'b0;
            end
            stage_info.value = horiz_value;
            if (vert_enable_ff) begin
               if (!odd_line_ff) begin
                  mem_we          = accept;
                  stage_info.emit = 1'b0;
               end else begin
                  mem_re         = accept;
                  stage_info.avg = 1'b1;
               end
               if (col_next >= eff_width) begin
                  column_count_in = '0;
                  odd_line_in     = ~odd_line_ff;
               end else begin
                  column_count_in = col_next[ADDR_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_sample_ff  <= '0;
         pair_half_ff    <= 1'b0;
         column_count_ff <= '0;
         odd_line_ff     <= 1'b0;
      end else if (accept) begin
         held_sample_ff  <= held_sample_in;
         pair_half_ff    <= pair_half_in;
         column_count_ff <= column_count_in;
         odd_line_ff     <= odd_line_in;
      end
   end

endmodule

// File: hw/rtl/csub_line_buf.sv
`timescale 1ns / 1ps

module csub_line_buf
   import csub_pkg::*;
#(
   parameter int MAX_LINE = CSUB_MAX_LINE,
   parameter int ADDR_W   = $clog2(MAX_LINE)
) (
   input  logic                clock,
   input  logic                mem_we,
   input  logic                mem_re,
   input  logic [ADDR_W-1:0]   mem_addr,
   input  logic [SAMPLE_W-1:0] mem_wdata,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] line_store_ff [MAX_LINE];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store_ff[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= line_store_ff[mem_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/csub_out_stage.sv
`timescale 1ns / 1ps

module csub_out_stage
   import csub_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  csub_stage_type      stage_info,
   input  logic [SAMPLE_W-1:0] rd_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output csub_rsp_type        rsp_data
);

   logic           mid_valid_ff;
   csub_stage_type mid_info_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   csub_rsp_type   rsp_data_ff, rsp_data_in;
   logic           mid_advance;
   logic           rsp_load;
   logic [SAMPLE_W:0] vert_sum;

   // items that give no result leave the middle stage without loading
   assign rsp_load    = mid_valid_ff && mid_info_ff.emit && (!rsp_valid_ff || rsp_ready);
   assign mid_advance = mid_valid_ff && (!mid_info_ff.emit || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !mid_valid_ff || mid_advance;

   assign vert_sum = {1'b0, rd_data} + {1'b0, mid_info_ff.value};

   always_comb begin
      rsp_data_in.out_is_luma = mid_info_ff.is_luma;
      rsp_data_in.out_sample  = mid_info_ff.avg ? vert_sum[SAMPLE_W:1] : mid_info_ff.value;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            mid_valid_ff <= 1'b1;
         end else if (mid_advance) begin
            mid_valid_ff <= 1'b0;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mid_info_ff <= stage_info;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/csub_checker.sv
`timescale 1ns / 1ps

module csub_checker
   import csub_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input csub_rsp_type           rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // reset empties the output
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input only backs up when a result is stuck at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // empty block with nothing in flight stays quiet
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !req_valid |=> !rsp_valid)
      else $error("result appeared from nothing");

endmodule

bind chroma_subsample_2x_top csub_checker u_csub_checker (.*);

// File: test/tb_chroma_subsample_2x_top.sv
`timescale 1ns / 1ps

module tb_chroma_subsample_2x_top;
   import csub_pkg::*;

   localparam int RANDOM_ITEMS    = 1100;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int HOLD_PHASE      = 4;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   csub_req_type           req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   csub_rsp_type           rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   chroma_subsample_2x_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   csub_req_type pending_req[$];
   csub_rsp_type expected_rsp[$];

   int unsigned sender_idle_pct = 10;
   int unsigned receiver_idle_pct = 71;
   bit          req_taken = 1'b0;
   bit          hold_request = 1'b0;
   bit          hold_off = 1'b0;
   int          failures = 0;

   // register mirror
   bit                    cfg_horiz = 1'b0;
   bit                    cfg_vert = 1'b0;
   logic [CSR_DATA_W-1:0] cfg_width = LINE_WIDTH_RESET;

   // chroma averaging state
   logic [SAMPLE_W-1:0] pair_first = '0;
   bit                  pair_open = 1'b0;
   int                  line_col = 0;
   bit                  line_odd = 1'b0;
   logic [SAMPLE_W-1:0] line_mem [CSUB_MAX_LINE];

   task automatic predict_subsample(input csub_req_type item);
      csub_rsp_type        r;
      logic [SAMPLE_W:0]   sum;
      logic [SAMPLE_W-1:0] value;
      int                  width;
      bit                  emit;
      emit = 1'b1;
      value = item.sample;
      if (!item.is_luma && cfg_horiz) begin
         if (!pair_open) begin
            pair_first = item.sample;
            pair_open = 1'b1;
            emit = 1'b0;
         end else begin
            sum = pair_first + item.sample;
            value = sum[SAMPLE_W:1];
            pair_open = 1'b0;
         end
      end
      if (!item.is_luma && emit && cfg_vert) begin
         width = cfg_horiz ? int'(cfg_width >> 1) : int'(cfg_width);
         if (width == 0) width = 1;
         if (width > CSUB_MAX_LINE) width = CSUB_MAX_LINE;
         // a width change inside a line restarts the column, parity kept
         if (line_col >= width) line_col = 0;
         if (!line_odd) begin
            line_mem[line_col] = value;
            emit = 1'b0;
         end else begin
            sum = line_mem[line_col] + value;
            value = sum[SAMPLE_W:1];
         end
         line_col++;
         if (line_col >= width) begin
            line_col = 0;
            line_odd = !line_odd;
         end
      end
      if (emit) begin
         r.out_sample = value;
         r.out_is_luma = item.is_luma;
         expected_rsp.push_back(r);
      end
   endtask

   // input handshake feeds the predictor, result handshake is checked
   always @(posedge clock) begin
      csub_rsp_type want;
      if (!reset) begin
         req_taken = req_valid && req_ready;
         if (req_taken) predict_subsample(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected result: sample %0d luma %0d",
                           rsp_data.out_sample, rsp_data.out_is_luma);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.out_sample !== want.out_sample ||
                   rsp_data.out_is_luma !== want.out_is_luma) begin
                  failures++;
                  if (failures <= 10)
                     $display("mismatch: sample exp %0d got %0d, luma exp %0d got %0d",
                              want.out_sample, rsp_data.out_sample,
                              want.out_is_luma, rsp_data.out_is_luma);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_req.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_req.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !hold_off && ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // long receiver stall while the sender keeps offering items
   initial begin
      wait (hold_request);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0);
      // items that give no result may still be in the pipe
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_HORIZ_ENABLE: cfg_horiz = value[0];
         CSR_VERT_ENABLE:  cfg_vert = value[0];
         CSR_LINE_WIDTH:   cfg_width = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic push_item(input logic [SAMPLE_W-1:0] sample, input logic is_luma);
      csub_req_type item;
      item.sample = sample;
      item.is_luma = is_luma;
      pending_req.push_back(item);
   endtask

   task automatic push_random_item(output bit was_chroma);
      logic [SAMPLE_W-1:0] s;
      case ($urandom_range(15))
         0:       s = '0;
         1:       s = '1;
         default: s = SAMPLE_W'($urandom_range(255));
      endcase
      was_chroma = ($urandom_range(3) != 0);
      push_item(s, !was_chroma);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_line_width();
      case ($urandom_range(9))
         0:       return CSR_DATA_W'(2);
         1:       return CSR_DATA_W'(CSUB_MAX_LINE);
         2:       return CSR_DATA_W'($urandom_range(127));
         3:       return CSR_DATA_W'($urandom_range(3));
         default: return CSR_DATA_W'(2 * $urandom_range(1, 8));
      endcase
   endfunction

   initial begin
      int generated;
      int chroma_seen;
      int phase_len;
      int phase_count;
      bit was_chroma;
      generated = 0;
      chroma_seen = 0;
      phase_count = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: everything passes through
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h00, 1'b1);
      push_item(8'hFF, 1'b1);
      push_item(8'hAA, 1'b0);
      push_item(8'h55, 1'b1);
      wait_idle();

      // horizontal pairs, one of them split by luma
      write_csr(CSR_HORIZ_ENABLE, CSR_DATA_W'(1));
      push_item(8'hFF, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h00, 1'b0);
      push_item(8'h81, 1'b1);
      push_item(8'hFF, 1'b0);
      push_item(8'h01, 1'b0);
      push_item(8'h00, 1'b0);
      push_item(8'h55, 1'b0);
      push_item(8'hAA, 1'b0);
      wait_idle();

      // vertical pairs; narrowing the line mid-line restarts the column
      write_csr(CSR_HORIZ_ENABLE, CSR_DATA_W'(0));
      write_csr(CSR_VERT_ENABLE, CSR_DATA_W'(1));
      write_csr(CSR_LINE_WIDTH, CSR_DATA_W'(8));
      repeat (5) push_item(SAMPLE_W'($urandom_range(255)), 1'b0);
      wait_idle();
      write_csr(CSR_LINE_WIDTH, CSR_DATA_W'(4));
      repeat (4) push_item(SAMPLE_W'($urandom_range(255)), 1'b0);
      push_item(8'h3C, 1'b1);
      repeat (4) push_item(SAMPLE_W'($urandom_range(255)), 1'b0);
      wait_idle();

      // one full-width line pair so every line entry is written from here on
      write_csr(CSR_LINE_WIDTH, CSR_DATA_W'(CSUB_MAX_LINE));
      while (chroma_seen < 2 * CSUB_MAX_LINE) begin
         push_random_item(was_chroma);
         if (was_chroma) chroma_seen++;
         generated++;
      end

      while (generated < RANDOM_ITEMS) begin
         wait_idle();
         if (generated >= 750) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end else if (generated >= 400) begin
            sender_idle_pct = 71;
            receiver_idle_pct = 10;
         end
         write_csr(CSR_HORIZ_ENABLE, CSR_DATA_W'($urandom_range(1)));
         write_csr(CSR_VERT_ENABLE, CSR_DATA_W'($urandom_range(1)));
         write_csr(CSR_LINE_WIDTH, pick_line_width());
         phase_len = (phase_count == HOLD_PHASE) ? 80 : $urandom_range(10, 80);
         repeat (phase_len) push_random_item(was_chroma);
         generated += phase_len;
         if (phase_count == HOLD_PHASE) hold_request = 1'b1;
         phase_count++;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      failures += expected_rsp.size();
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/csub_pkg.sv
hw/rtl/csub_ctrl.sv
hw/rtl/csub_line_buf.sv
hw/rtl/csub_out_stage.sv
hw/rtl/chroma_subsample_2x_top.sv
hw/rtl/csub_checker.sv
test/tb_chroma_subsample_2x_top.sv
